// ===== rtl/lfib_pkg.sv =====
// Shared types, codes and sizing constants for the lowest-free index binder.
// Used by the controller, the slot datapath and the top level. No dependencies.
package lfib_pkg;

    localparam int NUM_INDEXES = 8;
    localparam int KEY_BITS    = 8;
    localparam int IDX_BITS    = (NUM_INDEXES > 1) ? $clog2(NUM_INDEXES) : 1;

    localparam int CMD_BITS    = 2;
    localparam int SKEY_BITS   = 8;
    localparam int BIDX_BITS   = 3;
    localparam int STAT_BITS   = 3;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [IDX_BITS-1:0] t_idx;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [STAT_BITS-1:0] {
        ST_EXISTING = 3'd0,
        ST_NEW      = 3'd1,
        ST_FULL     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_MISS     = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [SKEY_BITS-1:0] slice_key;
    } t_in_item;

    typedef struct packed {
        logic [BIDX_BITS-1:0] bound_index;
        t_status              status;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic out_take;
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic out_valid;
    } t_dp_sts;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

// ===== rtl/lfib_ctrl.sv =====
// Sequencing controller for the lowest-free index binder: capture, then execute.
// Depends on lfib_pkg for the state, command and status structs.
module lfib_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_out_stall,
    input  lfib_pkg::t_dp_sts i_sts,
    output lfib_pkg::t_ctl   o_ctl
);
    import lfib_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_take = i_sts.out_valid && !i_out_stall;

    always_comb begin
        n_state        = r_state;
        o_ctl.load_in  = 1'b0;
        o_ctl.exec     = 1'b0;
        o_ctl.out_take = w_take;
        o_in_stall     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_in_stall = 1'b1;
                // hold until the result register is free or drains this cycle
                if (!i_sts.out_valid || w_take) begin
                    o_ctl.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lfib_datapath.sv =====
// Slot table, parallel key compare, lowest-free search and result register.
// Depends on lfib_pkg; driven by lfib_ctrl through the t_ctl command struct.
module lfib_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfib_pkg::t_ctl     i_ctl,
    input  lfib_pkg::t_in_item i_in,
    output lfib_pkg::t_dp_sts  o_sts,
    output lfib_pkg::t_out_item o_out
);
    import lfib_pkg::*;

    logic [CMD_BITS-1:0]    r_cmd;
    t_key                   r_key;
    logic [NUM_INDEXES-1:0] r_slot_valid;
    t_key                   r_slot_key [NUM_INDEXES];
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [NUM_INDEXES-1:0] w_hit_vec;
    logic                   w_hit_any;
    t_idx                   w_hit_idx;
    logic                   w_free_any;
    t_idx                   w_free_idx;
    t_idx                   w_res_idx;
    t_status                w_res_status;

    // Compare every slot and pick the lowest hit and the lowest free slot
    always_comb begin
        w_hit_any  = 1'b0;
        w_hit_idx  = '0;
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = 0; i < NUM_INDEXES; i++) begin
            w_hit_vec[i] = r_slot_valid[i] && (r_slot_key[i] == r_key);
        end
        for (int i = NUM_INDEXES - 1; i >= 0; i--) begin
            if (w_hit_vec[i]) begin
                w_hit_any = 1'b1;
                w_hit_idx = IDX_BITS'(i);
            end
            if (!r_slot_valid[i]) begin
                w_free_any = 1'b1;
                w_free_idx = IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        w_res_idx    = '0;
        w_res_status = ST_MISS;
        unique case (r_cmd)
            CMD_ACQUIRE: begin
                if (w_hit_any) begin
                    w_res_idx    = w_hit_idx;
                    w_res_status = ST_EXISTING;
                end else if (w_free_any) begin
                    w_res_idx    = w_free_idx;
                    w_res_status = ST_NEW;
                end else begin
                    w_res_status = ST_FULL;
                end
            end
            CMD_RELEASE: begin
                if (w_hit_any) begin
                    w_res_idx    = w_hit_idx;
                    w_res_status = ST_RELEASED;
                end
            end
            CMD_CLEAR: begin
                w_res_status = ST_CLEARED;
            end
            default: begin
                w_res_status = ST_MISS;
            end
        endcase
    end

    // Input capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd <= i_in.cmd;
            r_key <= KEY_BITS'(i_in.slice_key);
        end
        if (i_ctl.exec) begin
            r_out.bound_index <= BIDX_BITS'(w_res_idx);
            r_out.status      <= w_res_status;
        end
        if (i_ctl.exec && (r_cmd == CMD_ACQUIRE) && !w_hit_any && w_free_any) begin
            r_slot_key[w_free_idx] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_ctl.out_take) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.exec) begin
                unique case (r_cmd)
                    CMD_ACQUIRE: begin
                        if (!w_hit_any && w_free_any) begin
                            r_slot_valid[w_free_idx] <= 1'b1;
                        end
                    end
                    CMD_RELEASE: begin
                        if (w_hit_any) begin
                            r_slot_valid[w_hit_idx] <= 1'b0;
                        end
                    end
                    CMD_CLEAR: begin
                        r_slot_valid <= '0;
                    end
                    default: begin
                        r_slot_valid <= r_slot_valid;
                    end
                endcase
            end
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_out           = r_out;

    // A key is bound to at most one slot
    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit_vec))
        else $error("key matches more than one slot");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.exec |-> (!r_out_valid || i_ctl.out_take))
        else $error("result register overwritten");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && (r_cmd == CMD_CLEAR)) |=> (r_slot_valid == '0))
        else $error("clear left a binding");

    a_new_bind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && (w_res_status == ST_NEW)) |=> r_slot_valid[$past(w_free_idx)])
        else $error("new binding not marked valid");

endmodule

// ===== rtl/lowest_free_index_binder_core.sv =====
// Lowest-free index binder: the capture-then-execute controller sequence captures an item
// and then executes it, and takes no new item until that one has executed;
// a result waiting in the output register does not block the capture of the next item,
// but execution holds while that register is still full. Acquire returns the index bound
// to the key or binds the lowest free index; release frees it; clear drops all bindings.
// Depends on lfib_pkg, lfib_ctrl and lfib_datapath.
module lowest_free_index_binder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lfib_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lfib_pkg::t_out_item o_out
);
    import lfib_pkg::*;

    t_ctl    w_ctl;
    t_dp_sts w_sts;

    lfib_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    lfib_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_in    (i_in),
        .o_sts   (w_sts),
        .o_out   (o_out)
    );

    assign o_out_valid = w_sts.out_valid;

endmodule
